FILE: sv/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants for the contiguous allocator
// Sizes, field widths, status codes and the broadcast mark command.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

  // Storage sizes
  localparam int NUM_BLOCKS = 256;
  localparam int NUM_FILES  = 64;

  // Derived widths
  localparam int BLK_W    = $clog2(NUM_BLOCKS);      // block index
  localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);  // block count, run length
  localparam int FILE_W   = $clog2(NUM_FILES);       // file table index
  localparam int ISSUED_W = $clog2(NUM_FILES + 1);   // ids issued so far

  // Fixed word field widths
  localparam int LEN_W   = 9;
  localparam int ID_W    = 6;
  localparam int STAT_W  = 3;
  localparam int BLKF_W  = 8;
  localparam int LIMIT_W = 9;

  // Usable block count after reset: the bitmap size, saturated to 256
  localparam int LIMIT_RST = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO    = 3'd4
  } status_e;

  // Request codes
  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Range mark broadcast to every cell: set or clear blocks lo..hi
  typedef struct packed {
    logic             en;
    logic             set;
    logic [BLK_W-1:0] lo;
    logic [BLK_W-1:0] hi;
  } mark_t;

endpackage

`default_nettype wire

FILE: sv/contiguous_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator_top: first-fit contiguous block allocator
// Create and delete requests against a block bitmap and a file table.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid_i / in_stall_o): req_type_i 0 creates a file of
//   length_i blocks, 1 deletes file_id_i. One request is worked on at a time;
//   in_stall_o is high from acceptance until its result word is registered.
//   Result channel (out_valid_o / out_stall_i): one word per request with
//   status, file id and the first and last block of the run. Config channel
//   (cfg_valid_i / cfg_ready_o): total_blocks, always ready; values above the
//   bitmap size saturate. The user writes it only while idle; not enforced.
// Timing
//   A create walks the cell row one block per cycle from block zero until
//   the end block of the run, or the last usable block when no run fits.
//   A delete frees its run in one broadcast. A new request is taken the
//   cycle after the result word is registered, even while that word is
//   still stalled.
// Reset
//   All blocks free, no files issued, total_blocks 256. A stalled result word
//   holds; the block waits in its response state until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_first_fit_allocator_top import cfa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LIMIT_W-1:0] cfg_data_i,
  // requests
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [LEN_W-1:0]   length_i,
  input  wire logic [ID_W-1:0]    file_id_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [ID_W-1:0]         out_file_id_o,
  output logic [BLKF_W-1:0]       start_block_o,
  output logic [BLKF_W-1:0]       end_block_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_DRD    = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // request word
  logic             req_type_q;
  logic [LEN_W-1:0] len_q;
  logic [ID_W-1:0]  id_q;

  // control state
  logic [CNT_W-1:0]    limit_q;
  logic [ISSUED_W-1:0] issued_q, issued_d;
  logic [NUM_FILES-1:0] live_q, live_d;
  logic [BLK_W-1:0]    pos_q, pos_d;
  mark_t               mark_q, mark_d;

  // pending result
  status_e           res_st_q, res_st_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [BLKF_W-1:0] res_s_q, res_s_d;
  logic [BLKF_W-1:0] res_e_q, res_e_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              load_out;
  status_e           out_st_q;
  logic [ID_W-1:0]   out_id_q;
  logic [BLKF_W-1:0] out_s_q, out_e_q;

  // file table
  logic [BLK_W-1:0] file_start_mem [NUM_FILES];
  logic [BLK_W-1:0] file_end_mem   [NUM_FILES];
  logic [BLK_W-1:0] rd_start_q, rd_end_q;
  logic             tbl_we, rd_en;

  // search
  logic             start, kill, hit, off_end;
  logic [BLK_W-1:0] first_blk;
  logic [FILE_W-1:0] new_idx, del_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  assign start     = (state_q == S_SEARCH) && (pos_q == '0);
  assign first_blk = BLK_W'(32'(pos_q) + 1 - 32'(len_q));
  assign new_idx   = issued_q[FILE_W-1:0];
  assign del_idx   = id_q[FILE_W-1:0];

  // Bitmap cell row
  cfa_row u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .len_i     (len_q),
    .kill_i    (kill),
    .mark_i    (mark_q),
    .hit_o     (hit),
    .off_end_o (off_end)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    issued_d    = issued_q;
    live_d      = live_q;
    mark_d      = '0;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_s_d     = res_s_q;
    res_e_d     = res_e_q;
    tbl_we      = 1'b0;
    rd_en       = 1'b0;
    kill        = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_id_d = '0;
        res_s_d  = '0;
        res_e_d  = '0;
        if (req_type_q == REQ_CREATE) begin
          if (len_q == '0) begin
            res_st_d = ST_ZERO;
            state_d  = S_RESP;
          end else if (32'(issued_q) >= NUM_FILES) begin
            res_st_d = ST_FULL;
            state_d  = S_RESP;
          end else if (limit_q == '0) begin
            res_st_d = ST_NOSPACE;
            state_d  = S_RESP;
          end else begin
            pos_d   = '0;
            state_d = S_SEARCH;
          end
        end else begin
          res_id_d = id_q;
          if (32'(id_q) >= 32'(issued_q)) begin
            res_st_d = ST_UNKNOWN;
            state_d  = S_RESP;
          end else begin
            rd_en   = 1'b1;
            state_d = S_DRD;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          mark_d           = '{en: 1'b1, set: 1'b1, lo: first_blk, hi: pos_q};
          tbl_we           = 1'b1;
          live_d[new_idx]  = 1'b1;
          issued_d         = issued_q + ISSUED_W'(1);
          res_st_d         = ST_OK;
          res_id_d         = ID_W'(issued_q);
          res_s_d          = BLKF_W'(first_blk);
          res_e_d          = BLKF_W'(pos_q);
          state_d          = S_RESP;
        end else if ((32'(pos_q) + 1 == 32'(limit_q)) || off_end) begin
          kill     = 1'b1;
          res_st_d = ST_NOSPACE;
          state_d  = S_RESP;
        end else begin
          pos_d = pos_q + BLK_W'(1);
        end
      end

      S_DRD: begin
        res_st_d = ST_OK;
        if (live_q[del_idx]) begin
          mark_d          = '{en: 1'b1, set: 1'b0, lo: rd_start_q, hi: rd_end_q};
          live_d[del_idx] = 1'b0;
          res_s_d         = BLKF_W'(rd_start_q);
          res_e_d         = BLKF_W'(rd_end_q);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= '0;
      live_q      <= '0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= CNT_W'(LIMIT_RST);
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      live_q      <= live_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (32'(cfg_data_i) > NUM_BLOCKS) begin
          limit_q <= CNT_W'(NUM_BLOCKS);
        end else begin
          limit_q <= CNT_W'(cfg_data_i);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    res_st_q <= res_st_d;
    res_id_q <= res_id_d;
    res_s_q  <= res_s_d;
    res_e_q  <= res_e_d;
    if (state_q == S_IDLE && in_valid_i) begin
      req_type_q <= req_type_i;
      len_q      <= length_i;
      id_q       <= file_id_i;
    end
    if (load_out) begin
      out_st_q <= res_st_q;
      out_id_q <= res_id_q;
      out_s_q  <= res_s_q;
      out_e_q  <= res_e_q;
    end
  end

  // File table memory, registered read
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      file_start_mem[new_idx] <= first_blk;
      file_end_mem[new_idx]   <= pos_q;
    end
    if (rd_en) begin
      rd_start_q <= file_start_mem[del_idx];
      rd_end_q   <= file_end_mem[del_idx];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign out_file_id_o = out_id_q;
  assign start_block_o = out_s_q;
  assign end_block_o   = out_e_q;

endmodule

`default_nettype wire

FILE: sv/cfa_cell.sv
// ----------------------------------------------------------------------------
// cfa_cell: one block of the use bitmap
// Holds the use flag, evaluates the search token on its way past and
// forwards the free-run count to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_cell import cfa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [BLK_W-1:0] idx_i,
  input  wire logic [LEN_W-1:0] len_i,
  input  wire logic             kill_i,
  input  wire mark_t            mark_i,
  input  wire logic             tok_i,
  input  wire logic [CNT_W-1:0] run_i,
  output logic                  tok_o,
  output logic [CNT_W-1:0]      run_o,
  output logic                  hit_o
);

  logic             used_q, used_d;
  logic             tok_q, tok_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] run_inc;
  logic             in_rng;

  // Token evaluation: extend or break the free run
  always_comb begin
    run_inc = run_i + CNT_W'(1);
    hit_o   = tok_i && !used_q && (32'(run_inc) == 32'(len_i));
    tok_d   = tok_i && !hit_o && !kill_i;
    run_d   = used_q ? '0 : run_inc;
  end

  // Range mark from the controller
  always_comb begin
    in_rng = (idx_i >= mark_i.lo) && (idx_i <= mark_i.hi);
    used_d = (mark_i.en && in_rng) ? mark_i.set : used_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  // run count travels with the token, no reset needed
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  assign tok_o = tok_q;
  assign run_o = run_q;

endmodule

`default_nettype wire

FILE: sv/cfa_row.sv
// ----------------------------------------------------------------------------
// cfa_row: chain of bitmap cells
// Links the cells left to right; the search token enters at block zero and
// moves one block per cycle. Hits from all cells are gathered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_row import cfa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [LEN_W-1:0] len_i,
  input  wire logic             kill_i,
  input  wire mark_t            mark_i,
  output logic                  hit_o,
  output logic                  off_end_o
);

  logic [NUM_BLOCKS:0]   tok;
  logic [CNT_W-1:0]      run [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] hit;

  assign tok[0] = start_i;
  assign run[0] = '0;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    cfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (BLK_W'(k)),
      .len_i  (len_i),
      .kill_i (kill_i),
      .mark_i (mark_i),
      .tok_i  (tok[k]),
      .run_i  (run[k]),
      .tok_o  (tok[k+1]),
      .run_o  (run[k+1]),
      .hit_o  (hit[k])
    );
  end

  // Only one token is ever in flight, so a plain OR gives its hit
  assign hit_o = |hit;

  // Token left the last block without a hit
  assign off_end_o = tok[NUM_BLOCKS];

endmodule

`default_nettype wire

FILE: sim/tb_contiguous_first_fit_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_first_fit_allocator_top: self-checking bench for the allocator
// Creates and deletes are driven in bursts against a randomly stalled result
// port. Each accepted request is run through a first-fit model of the bitmap
// and file table, and every result word is compared field by field in order.
// The total_blocks register is stepped through its extremes between phases.
// ----------------------------------------------------------------------------

module tb_contiguous_first_fit_allocator_top;
  import cfa_pkg::*;

  // Request word and the result word it should produce
  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  fid;
  } req_t;

  typedef struct {
    status_e           st;
    logic [ID_W-1:0]   fid;
    logic [BLKF_W-1:0] first_blk;
    logic [BLKF_W-1:0] last_blk;
  } answer_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_e;

  // Clock, reset and block ports
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               req_type_i    = REQ_CREATE;
  logic [LEN_W-1:0]   length_i      = '0;
  logic [ID_W-1:0]    file_id_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [STAT_W-1:0]  status_o;
  logic [ID_W-1:0]    out_file_id_o;
  logic [BLKF_W-1:0]  start_block_o;
  logic [BLKF_W-1:0]  end_block_o;

  // Allocator image kept by the bench
  bit                blk_used [NUM_BLOCKS];
  logic [BLKF_W-1:0] f_first  [NUM_FILES];
  logic [BLKF_W-1:0] f_last   [NUM_FILES];
  bit                f_live   [NUM_FILES];
  int unsigned       files_out = 0;
  int unsigned       total_lim = 256;

  // Traffic bookkeeping
  req_t    req_queue[$];
  answer_t answers_due[$];
  int      n_queued  = 0;
  int      n_checked = 0;
  int      n_err     = 0;

  // Sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall pattern
  stall_e stall_mode = STALL_NONE;
  int     mode_left  = 0;

  always #10 clk_i = ~clk_i;

  contiguous_first_fit_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .length_i      (length_i),
    .file_id_i     (file_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_file_id_o (out_file_id_o),
    .start_block_o (start_block_o),
    .end_block_o   (end_block_o)
  );

  // Mismatch report; log kept short, count kept exact
  task automatic flag(input string msg);
    if (n_err < 100) $display("%0t ns mismatch: %s", $time, msg);
    n_err++;
  endtask

  // First-fit model: applies one request to the image, returns its result word
  function automatic answer_t alloc_predict(input logic kind, input logic [LEN_W-1:0] len,
                                            input logic [ID_W-1:0] fid);
    answer_t     a;
    int unsigned lim, run_len, k, b, first, last;
    bit          found;
    a.st        = ST_OK;
    a.fid       = '0;
    a.first_blk = '0;
    a.last_blk  = '0;
    if (kind == REQ_CREATE) begin
      if (len == 0) begin
        a.st = ST_ZERO;
      end else if (files_out >= NUM_FILES) begin
        a.st = ST_FULL;
      end else begin
        lim     = (total_lim > NUM_BLOCKS) ? NUM_BLOCKS : total_lim;
        run_len = 0;
        found   = 1'b0;
        first   = 0;
        last    = 0;
        // lowest start whose whole run fits below the usable count
        for (k = 0; k < lim && !found; k++) begin
          if (blk_used[k]) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == len) begin
              found = 1'b1;
              first = k + 1 - len;
              last  = k;
            end
          end
        end
        if (!found) begin
          a.st = ST_NOSPACE;
        end else begin
          for (b = first; b <= last; b++) blk_used[b] = 1'b1;
          f_first[files_out] = first[BLKF_W-1:0];
          f_last[files_out]  = last[BLKF_W-1:0];
          f_live[files_out]  = 1'b1;
          a.fid       = files_out[ID_W-1:0];
          a.first_blk = first[BLKF_W-1:0];
          a.last_blk  = last[BLKF_W-1:0];
          files_out++;
        end
      end
    end else begin
      a.fid = fid;
      if (fid >= files_out) begin
        a.st = ST_UNKNOWN;
      end else if (f_live[fid]) begin
        // a second delete of the same file frees nothing
        for (b = 32'(f_first[fid]); b <= 32'(f_last[fid]); b++) blk_used[b] = 1'b0;
        f_live[fid] = 1'b0;
        a.first_blk = f_first[fid];
        a.last_blk  = f_last[fid];
      end
    end
    return a;
  endfunction

  // Request driver: bursts of words with random gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin : req_drive
    req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        answers_due.push_back(alloc_predict(req_type_i, length_i, file_id_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (req_queue.size() != 0) begin
          nxt = req_queue.pop_front();
          req_type_i <= nxt.kind;
          length_i   <= nxt.len;
          file_id_i  <= nxt.fid;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall pattern
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    answer_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= STALL_NONE;
      mode_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          flag("result word with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          if (status_o !== want.st)
            flag($sformatf("status got %0d want %0d", status_o, want.st));
          if (out_file_id_o !== want.fid)
            flag($sformatf("file id got %0d want %0d", out_file_id_o, want.fid));
          if (start_block_o !== want.first_blk)
            flag($sformatf("start block got %0d want %0d", start_block_o, want.first_blk));
          if (end_block_o !== want.last_blk)
            flag($sformatf("end block got %0d want %0d", end_block_o, want.last_blk));
        end
        n_checked++;
      end
      if (mode_left == 0) begin
        stall_mode <= stall_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  task automatic push_req(input logic kind, input logic [LEN_W-1:0] len,
                          input logic [ID_W-1:0] fid);
    req_t r;
    r.kind = kind;
    r.len  = len;
    r.fid  = fid;
    req_queue.push_back(r);
    n_queued++;
  endtask

  // Wait until every request has its result, then let the block settle
  task automatic wait_idle();
    do @(posedge clk_i); while (n_checked < n_queued);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [LIMIT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_lim = 32'(v);
  endtask

  // Random phase: mostly deletes at issued ids, creates mostly sized to the limit
  task automatic queue_random(input int n);
    req_t        r;
    int unsigned est_ids, lim, pick, sub;
    est_ids = files_out;
    lim     = (total_lim > NUM_BLOCKS) ? NUM_BLOCKS : total_lim;
    repeat (n) begin
      r.len = LEN_W'($urandom);
      r.fid = ID_W'($urandom);
      pick  = $urandom_range(0, 99);
      sub   = $urandom_range(0, 99);
      if (pick < 14) begin
        r.kind = REQ_CREATE;
        if (sub < 4)       r.len = '0;
        else if (sub < 10) r.len = LEN_W'($urandom_range(257, 511));
        else if (sub < 22) r.len = LEN_W'($urandom_range(1, 256));
        else               r.len = LEN_W'($urandom_range(1, lim / 4 + 1));
        if (est_ids < NUM_FILES) est_ids++;
      end else begin
        r.kind = REQ_DELETE;
        if (sub < 85 && est_ids > 0) r.fid = ID_W'($urandom_range(0, est_ids - 1));
      end
      push_req(r.kind, r.len, r.fid);
    end
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int unsigned limits [14];
    limits = '{256, 64, 511, 8, 1, 200, 300, 0, 32, 256, 100, 17, 256, 3};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: error answers, full-disk file, hole reuse, repeated delete
    write_total(9'd256);
    push_req(REQ_CREATE, 9'd0,   6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd0);
    push_req(REQ_DELETE, 9'($urandom), 6'd63);
    push_req(REQ_CREATE, 9'd256, 6'($urandom));
    push_req(REQ_CREATE, 9'd1,   6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd0);
    push_req(REQ_DELETE, 9'($urandom), 6'd0);
    push_req(REQ_CREATE, 9'd1,   6'($urandom));
    push_req(REQ_CREATE, 9'd3,   6'($urandom));
    push_req(REQ_CREATE, 9'd2,   6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd2);
    push_req(REQ_CREATE, 9'd2,   6'($urandom));
    push_req(REQ_CREATE, 9'd2,   6'($urandom));
    push_req(REQ_CREATE, 9'd1,   6'($urandom));
    push_req(REQ_CREATE, 9'd511, 6'($urandom));
    push_req(REQ_CREATE, 9'd248, 6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd7);
    push_req(REQ_DELETE, 9'($urandom), 6'd63);
    wait_idle();

    // no usable blocks at all
    write_total(9'd0);
    push_req(REQ_CREATE, 9'd1, 6'($urandom));
    push_req(REQ_CREATE, 9'd0, 6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd1);
    wait_idle();

    // single usable block
    write_total(9'd1);
    push_req(REQ_CREATE, 9'd1, 6'($urandom));
    push_req(REQ_CREATE, 9'd1, 6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd8);
    wait_idle();

    // oversized register saturates to the bitmap size
    write_total(9'd511);
    push_req(REQ_CREATE, 9'd248, 6'($urandom));
    push_req(REQ_DELETE, 9'($urandom), 6'd9);
    wait_idle();

    // random phases over a spread of limits; the file table fills on the way
    foreach (limits[i]) begin
      write_total(limits[i][LIMIT_W-1:0]);
      queue_random(100);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb_contiguous_first_fit_allocator_top: done, clean");
    end else begin
      $display("tb_contiguous_first_fit_allocator_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #40_000_000;
    $display("tb_contiguous_first_fit_allocator_top: done, errors");
    $finish;
  end

endmodule

FILE: files.f
sv/cfa_pkg.sv
sv/cfa_cell.sv
sv/cfa_row.sv
sv/contiguous_first_fit_allocator_top.sv
sim/tb_contiguous_first_fit_allocator_top.sv
